/* rtl/hcc_pkg.sv */
package hcc_pkg;

  // input beat fields
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  key_code;
    logic        char_valid;
    logic [15:0] char_code;
    logic        ctrl_held;
    logic        shift_held;
    logic        alt_held;
    logic        win_held;
    logic        alt_flag;
    logic        injected;
    logic [15:0] window_id;
    logic [31:0] timestamp;
  } in_t;

  // result beat fields
  typedef struct packed {
    logic        block;
    logic        inject;
    logic [20:0] codepoint;
    logic        mode_on;
  } out_t;

  // event kinds
  localparam logic [1:0] OP_DOWN = 2'd0;
  localparam logic [1:0] OP_UP   = 2'd1;

  // virtual key codes
  localparam logic [7:0] KEY_BACK   = 8'h08;
  localparam logic [7:0] KEY_ENTER  = 8'h0D;
  localparam logic [7:0] KEY_ESC    = 8'h1B;
  localparam logic [7:0] KEY_SPACE  = 8'h20;
  localparam logic [7:0] KEY_U      = 8'h55;
  localparam logic [7:0] KEY_OEM5   = 8'hDC;
  localparam logic [7:0] KEY_OEM102 = 8'hE2;
  localparam logic [15:0] CH_BACKSLASH = 16'h005C;

  // code point limits
  localparam int unsigned CNT_W  = 3;
  localparam int unsigned ACC_W  = 24;
  localparam logic [ACC_W-1:0] CP_MAX     = 24'h10FFFF;
  localparam logic [ACC_W-1:0] SURR_FIRST = 24'h00D800;
  localparam logic [ACC_W-1:0] SURR_LAST  = 24'h00DFFF;
  localparam logic [15:0] TIMEOUT_RESET = 16'd5000;

  // what one event does to the mode
  typedef enum logic [3:0] {
    ACT_PASS,
    ACT_ENTER,
    ACT_CANCEL_PASS,
    ACT_SWALLOW_U,
    ACT_BLOCK,
    ACT_CANCEL_BLOCK,
    ACT_DROP,
    ACT_COMMIT,
    ACT_DIGIT
  } act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_WALK,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic cap;
    logic walk_start;
    logic walk_step;
    logic apply;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    act_t act;
    logic walk_done;
  } sts_t;

  // hex character decode: {hit, value}
  function automatic logic [4:0] hex_decode(input logic [15:0] ch);
    logic [4:0] r;
    begin
      r = 5'd0;
      if (ch >= 16'h0030 && ch <= 16'h0039) begin
        r = {1'b1, 4'(ch - 16'h0030)};
      end else if (ch >= 16'h0061 && ch <= 16'h0066) begin
        r = {1'b1, 4'(ch - 16'h0057)};
      end else if (ch >= 16'h0041 && ch <= 16'h0046) begin
        r = {1'b1, 4'(ch - 16'h0037)};
      end
      return r;
    end
  endfunction

endpackage

/* rtl/hcc_ctrl.sv */
module hcc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  input  hcc_pkg::sts_t  sts,
  output hcc_pkg::cmd_t  cmd
);

  hcc_pkg::state_t state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hcc_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = hcc_pkg::ST_DECIDE;
      end
      hcc_pkg::ST_DECIDE: begin
        if (sts.act == hcc_pkg::ACT_COMMIT) state_nxt = hcc_pkg::ST_WALK;
        else state_nxt = hcc_pkg::ST_EMIT;
      end
      hcc_pkg::ST_WALK: begin
        if (sts.walk_done) state_nxt = hcc_pkg::ST_EMIT;
      end
      hcc_pkg::ST_EMIT: begin
        if (out_free) state_nxt = hcc_pkg::ST_IDLE;
      end
      default: state_nxt = hcc_pkg::ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      hcc_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        cmd.cap  = in_valid;
      end
      hcc_pkg::ST_DECIDE: begin
        cmd.walk_start = (sts.act == hcc_pkg::ACT_COMMIT);
      end
      hcc_pkg::ST_WALK: begin
        cmd.walk_step = !sts.walk_done;
      end
      hcc_pkg::ST_EMIT: begin
        cmd.apply = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.apply) out_valid_nxt = 1'b1;
    else if (!out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= hcc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* rtl/hcc_dp.sv */
module hcc_dp #(
  parameter int MAX_DIGITS = 6
) (
  input  logic           clk,
  input  logic           rst_n,
  input  hcc_pkg::in_t   in_data,
  input  logic           cfg_we,
  input  logic [15:0]    cfg_data,
  input  hcc_pkg::cmd_t  cmd,
  output hcc_pkg::sts_t  sts,
  output hcc_pkg::out_t  out_data
);

  localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam logic [hcc_pkg::CNT_W-1:0] LIMIT = hcc_pkg::CNT_W'(MAX_DIGITS);

  hcc_pkg::in_t item_r;
  logic [3:0] store_r [MAX_DIGITS];
  logic active_r, active_nxt;
  logic [hcc_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [15:0] start_win_r, start_win_nxt;
  logic [31:0] last_act_r, last_act_nxt;
  logic swallow_r, swallow_nxt;
  logic [15:0] timeout_r;
  logic [hcc_pkg::ACC_W-1:0] acc_r;
  logic [hcc_pkg::CNT_W-1:0] widx_r;
  hcc_pkg::out_t out_r;

  hcc_pkg::act_t act;
  logic [4:0] hex;
  logic [31:0] elapsed;
  logic down, up, is_bslash, room, blk, cp_ok;

  assign down      = (item_r.op == hcc_pkg::OP_DOWN);
  assign up        = (item_r.op == hcc_pkg::OP_UP);
  assign hex       = hcc_pkg::hex_decode(item_r.char_code);
  assign elapsed   = item_r.timestamp - last_act_r;
  assign room      = (count_r < LIMIT);
  assign is_bslash = (item_r.key_code == hcc_pkg::KEY_OEM5) ||
                     (item_r.key_code == hcc_pkg::KEY_OEM102) ||
                     (down && item_r.char_valid &&
                      item_r.char_code == hcc_pkg::CH_BACKSLASH) ||
                     (item_r.key_code == hcc_pkg::KEY_BACK);

  // classify the held event against the mode state
  always_comb begin
    act = hcc_pkg::ACT_PASS;
    if (item_r.injected) begin
      act = hcc_pkg::ACT_PASS;
    end else if (!active_r) begin
      if (down && item_r.key_code == hcc_pkg::KEY_U && item_r.ctrl_held &&
          item_r.shift_held && !item_r.alt_held && !item_r.win_held) begin
        act = hcc_pkg::ACT_ENTER;
      end
    end else if (elapsed > {16'd0, timeout_r} || item_r.window_id != start_win_r ||
                 item_r.alt_flag || item_r.win_held) begin
      act = hcc_pkg::ACT_CANCEL_PASS;
    end else if (up && item_r.key_code == hcc_pkg::KEY_U && swallow_r) begin
      act = hcc_pkg::ACT_SWALLOW_U;
    end else if (item_r.key_code == hcc_pkg::KEY_ESC) begin
      act = down ? hcc_pkg::ACT_CANCEL_BLOCK : hcc_pkg::ACT_BLOCK;
    end else if (is_bslash) begin
      if (!down) act = hcc_pkg::ACT_BLOCK;
      else if (item_r.ctrl_held) act = hcc_pkg::ACT_CANCEL_BLOCK;
      else act = hcc_pkg::ACT_DROP;
    end else if (item_r.key_code == hcc_pkg::KEY_SPACE ||
                 item_r.key_code == hcc_pkg::KEY_ENTER) begin
      act = down ? hcc_pkg::ACT_COMMIT : hcc_pkg::ACT_BLOCK;
    end else if (down) begin
      act = (item_r.char_valid && hex[4]) ? hcc_pkg::ACT_DIGIT
                                          : hcc_pkg::ACT_CANCEL_PASS;
    end
  end

  assign sts.act       = act;
  assign sts.walk_done = (widx_r == count_r);

  // mode state update
  always_comb begin
    active_nxt    = active_r;
    count_nxt     = count_r;
    start_win_nxt = start_win_r;
    last_act_nxt  = last_act_r;
    swallow_nxt   = swallow_r;
    blk           = 1'b1;
    case (act)
      hcc_pkg::ACT_PASS: begin
        blk = 1'b0;
      end
      hcc_pkg::ACT_ENTER: begin
        active_nxt    = 1'b1;
        count_nxt     = '0;
        start_win_nxt = item_r.window_id;
        last_act_nxt  = item_r.timestamp;
        swallow_nxt   = 1'b1;
      end
      hcc_pkg::ACT_CANCEL_PASS, hcc_pkg::ACT_CANCEL_BLOCK, hcc_pkg::ACT_COMMIT: begin
        active_nxt    = 1'b0;
        count_nxt     = '0;
        start_win_nxt = '0;
        swallow_nxt   = 1'b0;
        blk           = (act != hcc_pkg::ACT_CANCEL_PASS);
      end
      hcc_pkg::ACT_SWALLOW_U: begin
        swallow_nxt = 1'b0;
      end
      hcc_pkg::ACT_BLOCK: begin
        blk = 1'b1;
      end
      hcc_pkg::ACT_DROP: begin
        if (count_r != '0) count_nxt = count_r - 1'b1;
        last_act_nxt = item_r.timestamp;
      end
      hcc_pkg::ACT_DIGIT: begin
        if (room) count_nxt = count_r + 1'b1;
        last_act_nxt = item_r.timestamp;
      end
      default: blk = 1'b0;
    endcase
  end

  // commit check on the assembled value
  assign cp_ok = (count_r != '0) && (acc_r <= hcc_pkg::CP_MAX) &&
                 !(acc_r >= hcc_pkg::SURR_FIRST && acc_r <= hcc_pkg::SURR_LAST);

  // mode state registers and timeout config
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      count_r     <= '0;
      start_win_r <= '0;
      last_act_r  <= '0;
      swallow_r   <= 1'b0;
      timeout_r   <= hcc_pkg::TIMEOUT_RESET;
    end else begin
      if (cmd.apply) begin
        active_r    <= active_nxt;
        count_r     <= count_nxt;
        start_win_r <= start_win_nxt;
        last_act_r  <= last_act_nxt;
        swallow_r   <= swallow_nxt;
      end
      if (cfg_we) timeout_r <= cfg_data;
    end
  end

  // event capture, digit store, walk accumulator, result register
  always_ff @(posedge clk) begin
    if (cmd.cap) item_r <= in_data;
    if (cmd.apply && act == hcc_pkg::ACT_DIGIT && room) begin
      store_r[count_r[IDX_W-1:0]] <= hex[3:0];
    end
    if (cmd.walk_start) begin
      acc_r  <= '0;
      widx_r <= '0;
    end else if (cmd.walk_step) begin
      acc_r  <= {acc_r[hcc_pkg::ACC_W-5:0], store_r[widx_r[IDX_W-1:0]]};
      widx_r <= widx_r + 1'b1;
    end
    if (cmd.apply) begin
      out_r.block     <= blk;
      out_r.inject    <= (act == hcc_pkg::ACT_COMMIT) && cp_ok;
      out_r.codepoint <= ((act == hcc_pkg::ACT_COMMIT) && cp_ok) ? acc_r[20:0] : 21'd0;
      out_r.mode_on   <= active_nxt;
    end
  end

  assign out_data = out_r;

endmodule

/* rtl/hex_codepoint_compose_fsm_unit.sv */
// sequence: an accepted event goes through DECIDE, then EMIT registers its
//   result; a Space or Enter commit first walks the stored hex digits in WALK
// flow: one event in flight; a new event is taken only once the last result is
//   registered; a commit steps through the single-read digit store digit by
//   digit, and a result held by out_stall holds off the next result until it is taken
// reset: synchronous active-low rst_n clears mode, digit count, window, timer
//   and the timeout register (5000 ms); no result is pending after reset
module hex_codepoint_compose_fsm_unit #(
  parameter int MAX_DIGITS = 6
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  hcc_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output hcc_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [15:0]   cfg_data
);

  hcc_pkg::cmd_t cmd;
  hcc_pkg::sts_t sts;

  // sequencer
  hcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // mode state, digit store and result register
  hcc_dp #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // one event in flight: busy right after a beat is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input taken while an event is in flight");

  // a committed code point is always consumed and closes the mode
  a_inject_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.inject) |-> (out_data.block && !out_data.mode_on))
    else $error("inject without block or with mode still on");

  // code point is zero unless injected
  a_cp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.inject) |-> (out_data.codepoint == 21'd0))
    else $error("code point present without inject");

endmodule
